/* src/crwp_pkg.sv */
package crwp_pkg;

  // Number formats. Coordinates are 32-bit signed fixed point; basis
  // components carry BASIS_FRAC fraction bits.
  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 8;
  localparam int BASIS_FRAC = 24;
  localparam int SMALL_EXP  = 20;
  localparam int SAT_BITS   = (COORD_BITS < 32) ? COORD_BITS : 32;

  // Zero-length thresholds for the right and up vectors, in their own units.
  localparam int T_RIGHT = BASIS_FRAC + FRAC_BITS - SMALL_EXP;
  localparam int T_UP    = 2 * BASIS_FRAC - SMALL_EXP;

  // Working widths.
  localparam int W_W = 60;  // cross product or difference vector
  localparam int M_W = 58;  // magnitude of a working component
  localparam int B_W = 26;  // basis component, magnitude at most 2^24

  localparam logic [M_W-1:0] TH_RIGHT    = M_W'(1) << T_RIGHT;
  localparam logic [M_W-1:0] TH_UP       = M_W'(1) << T_UP;
  localparam logic [63:0]    TH_RIGHT_SQ = 64'(1) << (2 * T_RIGHT);
  localparam logic [63:0]    TH_UP_SQ    = 64'(1) << (2 * T_UP);
  localparam logic signed [B_W-1:0] BASIS_ONE = B_W'(1) << BASIS_FRAC;

  typedef enum logic [2:0] {
    CMD_LOAD_EYE    = 3'd0,
    CMD_LOAD_TARGET = 3'd1,
    CMD_LOAD_UP     = 3'd2,
    CMD_ABSENT      = 3'd3,
    CMD_TRANSFORM   = 3'd4
  } cmd_t;

  typedef enum logic {
    IT_SQRT = 1'b0,
    IT_DIV  = 1'b1
  } iter_mode_t;

  typedef struct packed {
    logic go;
    logic clr;
    logic sub;
  } mac_ctl_t;

  function automatic logic [31:0] sat_coord(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = (64'sd1 <<< (SAT_BITS - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    if (v > hi) return hi[31:0];
    if (v < lo) return lo[31:0];
    return v[31:0];
  endfunction

endpackage

/* src/camera_relative_to_world_position.sv */
// Channel   Dir  Signals                    Contents
// s_*       in   tvalid tready tdata tuser  tdata: vec_x, vec_y, vec_z; tuser: command, follow
// m_*       out  tvalid tready tdata        tdata: world_x, world_y, world_z
//
// Load and absent commands update the camera state and the block stays ready.
// A pass-through transform goes through the output state to the output register.
// A camera transform runs three normalizations on one shared multiply-accumulate
// unit and one shared square-root/divide unit. A full normalization shifts the
// magnitudes down as needed, then runs a 32-step square root and three 25-step
// divisions; each fallback axis skips its square root and divisions.
// Reset is synchronous and clears the camera and all control state.
// A finished result waits in the output state while an earlier one is stalled in
// the output register; the input is not ready until that register frees.
module camera_relative_to_world_position (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // vec_x [31:0], vec_y [63:32], vec_z [95:64]
  input  logic [3:0]   s_tuser,   // command [2:0], follow_camera [3]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata    // world_x [31:0], world_y [63:32], world_z [95:64]
);
  import crwp_pkg::*;

  typedef enum logic [13:0] {
    ST_IDLE   = 14'b00000000000001,
    ST_DIFF   = 14'b00000000000010,
    ST_NLOAD  = 14'b00000000000100,
    ST_NCHK   = 14'b00000000001000,
    ST_NSMALL = 14'b00000000010000,
    ST_NSHIFT = 14'b00000000100000,
    ST_NSUMSQ = 14'b00000001000000,
    ST_SQGO   = 14'b00000010000000,
    ST_SQWAIT = 14'b00000100000000,
    ST_DVGO   = 14'b00001000000000,
    ST_DVWAIT = 14'b00010000000000,
    ST_CROSS  = 14'b00100000000000,
    ST_FINAL  = 14'b01000000000000,
    ST_OUT    = 14'b10000000000000
  } state_t;

  state_t state;

  // Camera and input position.
  logic signed [31:0] eye [3];
  logic signed [31:0] tgt [3];
  logic signed [31:0] upv [3];
  logic signed [31:0] pos [3];
  logic               cam_known;

  // Basis, working vector and its magnitudes.
  logic signed [B_W-1:0] fwd [3];
  logic signed [B_W-1:0] rgt [3];
  logic signed [B_W-1:0] upb [3];
  logic signed [W_W-1:0] w [3];
  logic [M_W-1:0]        m [3];
  logic                  neg [3];

  logic [1:0]  sel;   // which normalization: forward, right, up
  logic [1:0]  ci;    // component index
  logic [2:0]  cnt;   // multiply-accumulate step
  logic [31:0] len;
  logic [31:0] res [3];

  logic               accept;
  logic [2:0]         cmd;
  logic               follow;
  logic signed [31:0] v [3];

  mac_ctl_t           mac_ctl;
  logic signed [31:0] mac_a;
  logic signed [31:0] mac_b;
  logic signed [63:0] mac_init;
  logic signed [63:0] mac_acc;
  logic [2:0]         mac_nops;
  logic               mac_done;

  logic        it_start;
  iter_mode_t  it_mode;
  logic [63:0] it_num;
  logic        it_busy;
  logic [31:0] it_res;

  logic [1:0]  mi;
  logic [1:0]  idx_j;
  logic [1:0]  idx_k;
  logic signed [31:0] avec [3];
  logic signed [31:0] bvec [3];
  logic        all_zero;
  logic        too_big;
  logic        small_ok;
  logic        sum_small;
  logic [B_W-1:0]     q_mag;
  logic signed [B_W-1:0] q_signed;
  logic signed [63:0] rounded;

  assign s_tready = state == ST_IDLE;
  assign accept   = s_tvalid && s_tready;
  assign cmd      = s_tuser[2:0];
  assign follow   = s_tuser[3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v[i] = s_tdata[32*i +: 32];
      avec[i] = (sel == 2'd2) ? 32'(rgt[i]) : 32'(fwd[i]);
      bvec[i] = (sel == 2'd2) ? 32'(fwd[i]) : upv[i];
    end
  end

  // Magnitude tests on the working vector.
  always_comb begin
    all_zero = 1'b1;
    too_big  = 1'b0;
    small_ok = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (m[i] != '0) all_zero = 1'b0;
      if (m[i][M_W-1:30] != '0) too_big = 1'b1;
      if (m[i] > ((sel == 2'd1) ? TH_RIGHT : TH_UP)) small_ok = 1'b0;
    end
    sum_small = mac_acc <= ((sel == 2'd1) ? TH_RIGHT_SQ : TH_UP_SQ);
  end

  always_comb begin
    case (ci)
      2'd0:    begin idx_j = 2'd1; idx_k = 2'd2; end
      2'd1:    begin idx_j = 2'd2; idx_k = 2'd0; end
      default: begin idx_j = 2'd0; idx_k = 2'd1; end
    endcase
    mi = (cnt[1:0] == 2'd3) ? 2'd2 : cnt[1:0];
  end

  // Operand selection for the shared multiply-accumulate unit.
  always_comb begin
    mac_ctl  = '0;
    mac_a    = '0;
    mac_b    = '0;
    mac_init = '0;
    mac_nops = 3'd3;
    case (state)
      ST_NSMALL, ST_NSUMSQ: begin
        mac_ctl.go  = cnt < 3'd3;
        mac_ctl.clr = cnt == 3'd0;
        mac_a = {2'b00, m[mi][29:0]};
        mac_b = {2'b00, m[mi][29:0]};
      end
      ST_CROSS: begin
        mac_nops    = 3'd2;
        mac_ctl.go  = cnt < 3'd2;
        mac_ctl.clr = cnt == 3'd0;
        mac_ctl.sub = cnt != 3'd0;
        mac_a = (cnt == 3'd0) ? avec[idx_j] : avec[idx_k];
        mac_b = (cnt == 3'd0) ? bvec[idx_k] : bvec[idx_j];
      end
      ST_FINAL: begin
        mac_ctl.go  = cnt < 3'd3;
        mac_ctl.clr = cnt == 3'd0;
        mac_ctl.sub = cnt == 3'd2;
        mac_init = 64'(eye[ci]) <<< BASIS_FRAC;
        case (mi)
          2'd0:    begin mac_a = 32'(rgt[ci]); mac_b = pos[0]; end
          2'd1:    begin mac_a = 32'(upb[ci]); mac_b = pos[1]; end
          default: begin mac_a = 32'(fwd[ci]); mac_b = pos[2]; end
        endcase
      end
      default: begin
      end
    endcase
    mac_done = cnt == mac_nops + 3'd1;
  end

  assign it_start = (state == ST_SQGO) || (state == ST_DVGO);
  assign it_mode  = (state == ST_SQGO) ? IT_SQRT : IT_DIV;
  assign it_num   = (state == ST_SQGO) ? mac_acc : (64'(m[ci]) << BASIS_FRAC);

  assign q_mag    = {1'b0, it_res[B_W-2:0]};
  assign q_signed = neg[ci] ? -q_mag : q_mag;
  assign rounded  = (mac_acc + (64'sd1 <<< (BASIS_FRAC - 1))) >>> BASIS_FRAC;

  crwp_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .a    (mac_a),
    .b    (mac_b),
    .init (mac_init),
    .acc  (mac_acc)
  );

  crwp_iter u_iter (
    .clk     (clk),
    .rst     (rst),
    .start   (it_start),
    .mode    (it_mode),
    .num     (it_num),
    .divisor (len),
    .busy    (it_busy),
    .result  (it_res)
  );

  // Sequencer. Each normalization ends either with a fallback axis or with
  // three divisions; after it the next cross product or the final sum runs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cam_known <= 1'b0;
      m_tvalid  <= 1'b0;
      sel       <= 2'd0;
      ci        <= 2'd0;
      cnt       <= 3'd0;
      for (int i = 0; i < 3; i++) begin
        eye[i] <= '0;
        tgt[i] <= '0;
        upv[i] <= '0;
      end
    end else begin
      // In the output state the register is reloaded instead of cleared.
      if (m_tvalid && m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (cmd)
              CMD_LOAD_EYE:    for (int i = 0; i < 3; i++) eye[i] <= v[i];
              CMD_LOAD_TARGET: for (int i = 0; i < 3; i++) tgt[i] <= v[i];
              CMD_LOAD_UP: begin
                for (int i = 0; i < 3; i++) upv[i] <= v[i];
                cam_known <= 1'b1;
              end
              CMD_ABSENT: cam_known <= 1'b0;
              CMD_TRANSFORM: begin
                for (int i = 0; i < 3; i++) begin
                  pos[i] <= v[i];
                  res[i] <= sat_coord(64'(v[i]));
                end
                state <= (follow && cam_known) ? ST_DIFF : ST_OUT;
              end
              default: begin
              end
            endcase
          end
        end
        ST_DIFF: begin
          for (int i = 0; i < 3; i++) begin
            w[i] <= W_W'(tgt[i]) - W_W'(eye[i]);
          end
          sel   <= 2'd0;
          state <= ST_NLOAD;
        end
        ST_NLOAD: begin
          for (int i = 0; i < 3; i++) begin
            m[i]   <= M_W'(w[i][W_W-1] ? -w[i] : w[i]);
            neg[i] <= w[i][W_W-1];
          end
          state <= ST_NCHK;
        end
        ST_NCHK: begin
          cnt <= 3'd0;
          if (sel == 2'd0) begin
            if (all_zero) begin
              fwd[0] <= '0;
              fwd[1] <= '0;
              fwd[2] <= -BASIS_ONE;
              sel    <= 2'd1;
              ci     <= 2'd0;
              state  <= ST_CROSS;
            end else begin
              state <= ST_NSHIFT;
            end
          end else begin
            state <= small_ok ? ST_NSMALL : ST_NSHIFT;
          end
        end
        ST_NSMALL: begin
          if (mac_done) begin
            cnt <= 3'd0;
            if (sum_small) begin
              ci <= 2'd0;
              if (sel == 2'd1) begin
                rgt[0] <= BASIS_ONE;
                rgt[1] <= '0;
                rgt[2] <= '0;
                sel    <= 2'd2;
                state  <= ST_CROSS;
              end else begin
                upb[0] <= '0;
                upb[1] <= BASIS_ONE;
                upb[2] <= '0;
                state  <= ST_FINAL;
              end
            end else begin
              state <= ST_NSHIFT;
            end
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        ST_NSHIFT: begin
          if (too_big) begin
            for (int i = 0; i < 3; i++) m[i] <= m[i] >> 1;
          end else begin
            cnt   <= 3'd0;
            state <= ST_NSUMSQ;
          end
        end
        ST_NSUMSQ: begin
          if (mac_done) begin
            cnt   <= 3'd0;
            state <= ST_SQGO;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        ST_SQGO: state <= ST_SQWAIT;
        ST_SQWAIT: begin
          if (!it_busy) begin
            len   <= (it_res == 32'd0) ? 32'd1 : it_res;
            ci    <= 2'd0;
            state <= ST_DVGO;
          end
        end
        ST_DVGO: state <= ST_DVWAIT;
        ST_DVWAIT: begin
          if (!it_busy) begin
            case (sel)
              2'd0:    fwd[ci] <= q_signed;
              2'd1:    rgt[ci] <= q_signed;
              default: upb[ci] <= q_signed;
            endcase
            if (ci == 2'd2) begin
              ci  <= 2'd0;
              cnt <= 3'd0;
              if (sel == 2'd2) begin
                state <= ST_FINAL;
              end else begin
                sel   <= sel + 2'd1;
                state <= ST_CROSS;
              end
            end else begin
              ci    <= ci + 2'd1;
              state <= ST_DVGO;
            end
          end
        end
        ST_CROSS: begin
          if (mac_done) begin
            cnt   <= 3'd0;
            w[ci] <= W_W'(mac_acc);
            if (ci == 2'd2) begin
              state <= ST_NLOAD;
            end else begin
              ci <= ci + 2'd1;
            end
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        ST_FINAL: begin
          if (mac_done) begin
            cnt     <= 3'd0;
            res[ci] <= sat_coord(rounded);
            if (ci == 2'd2) begin
              state <= ST_OUT;
            end else begin
              ci <= ci + 2'd1;
            end
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {res[2], res[1], res[0]};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* src/crwp_mac.sv */
module crwp_mac (
  input  logic                clk,
  input  logic                rst,
  input  crwp_pkg::mac_ctl_t  ctl,
  input  logic signed [31:0]  a,
  input  logic signed [31:0]  b,
  input  logic signed [63:0]  init,
  output logic signed [63:0]  acc
);
  import crwp_pkg::*;

  mac_ctl_t           ctl1;
  logic signed [63:0] prod;
  logic signed [63:0] init1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
    end else begin
      ctl1 <= ctl;
    end
    prod  <= a * b;
    init1 <= init;
  end

  always_ff @(posedge clk) begin
    if (ctl1.go) begin
      acc <= (ctl1.clr ? init1 : acc) + (ctl1.sub ? -prod : prod);
    end
  end

endmodule

/* src/crwp_iter.sv */
module crwp_iter (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  crwp_pkg::iter_mode_t  mode,
  input  logic [63:0]           num,
  input  logic [31:0]           divisor,
  output logic                  busy,
  output logic [31:0]           result
);
  import crwp_pkg::*;

  iter_mode_t  mode_r;
  logic [63:0] rem;
  logic [63:0] aux;
  logic [63:0] refv;
  logic [5:0]  cnt;
  logic [63:0] trial;
  logic        ge;

  // One compare-and-subtract per cycle serves both the square root and
  // the restoring division.
  assign trial  = (mode_r == IT_SQRT) ? aux + refv : refv;
  assign ge     = rem >= trial;
  assign busy   = cnt != 6'd0;
  assign result = aux[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 6'd0;
    end else if (start) begin
      cnt <= (mode == IT_SQRT) ? 6'd32 : 6'(BASIS_FRAC + 1);
    end else if (busy) begin
      cnt <= cnt - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mode_r <= mode;
      rem    <= num;
      aux    <= 64'd0;
      refv   <= (mode == IT_SQRT) ? (64'd1 << 62) : (64'(divisor) << BASIS_FRAC);
    end else if (busy) begin
      if (ge) begin
        rem <= rem - trial;
      end
      if (mode_r == IT_SQRT) begin
        aux  <= (aux >> 1) + (ge ? refv : 64'd0);
        refv <= refv >> 2;
      end else begin
        aux  <= {aux[62:0], ge};
        refv <= refv >> 1;
      end
    end
  end

endmodule

/* src/crwp_check.sv */
module crwp_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [3:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata
);
  import crwp_pkg::*;

  // No result is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered after reset");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // No item produces a result in the cycle after its transfer.
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
    else $error("result appeared too early");

  // A transform holds off further input while it is worked on.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser[2:0] == CMD_TRANSFORM |=> !s_tready)
    else $error("input accepted during a transform");

endmodule

bind camera_relative_to_world_position crwp_check u_crwp_check (.*);

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import crwp_pkg::*;

  // Codes 5 to 7 are not commands; the block must ignore them.
  localparam logic [2:0] CMD_SPARE_LO = 3'd5;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  // Longest run of cycles with no transfer on either side before we give up.
  // A camera transform and the long receiver hold-off both stay well within this
  // limit, so it leaves a wide margin.
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;

  typedef longint vec3_t [3];

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [95:0] s_tdata;   // vec_x [31:0], vec_y [63:32], vec_z [95:64]
  logic [3:0]  s_tuser;   // command [2:0], follow_camera [3]
  logic        m_tvalid;
  logic        m_tready;
  logic [95:0] m_tdata;   // world_x [31:0], world_y [63:32], world_z [95:64]

  camera_relative_to_world_position dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Shadow copy of the camera kept by the predictor.
  vec3_t cam_eye;
  vec3_t cam_target;
  vec3_t cam_up;
  bit    cam_known;

  // Expected world positions, oldest first, packed as on m_tdata.
  logic [95:0] world_pos_q[$];

  int src_idle_pct;
  int snk_idle_pct;
  bit hold_req;
  int errors;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Unit vector in Q2.24, or the fallback axis when the vector is no longer
  // than 2^t in its own units (t below zero means exactly zero).
  function automatic vec3_t unit_or(vec3_t v, int t, vec3_t fb);
    longint unsigned m[3];
    longint unsigned mx;
    longint unsigned sum;
    longint unsigned len;
    longint q;
    vec3_t o;
    int k;
    mx = 0;
    sum = 0;
    k = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (v[i] < 0) ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    if (t < 0) begin
      if (mx == 0) return fb;
    end else if (mx <= (64'd1 << t)) begin
      for (int i = 0; i < 3; i++) sum += m[i] * m[i];
      if (sum <= (64'd1 << (2 * t))) return fb;
      sum = 0;
    end
    while ((mx >> k) >= (64'd1 << 30)) k++;
    for (int i = 0; i < 3; i++) begin
      m[i] = m[i] >> k;
      sum += m[i] * m[i];
    end
    len = int_sqrt(sum);
    if (len == 0) len = 1;
    for (int i = 0; i < 3; i++) begin
      q = longint'((m[i] << BASIS_FRAC) / len);
      o[i] = (v[i] < 0) ? -q : q;
    end
    return o;
  endfunction

  function automatic vec3_t cross_prod(vec3_t a, vec3_t b);
    vec3_t o;
    o[0] = a[1] * b[2] - a[2] * b[1];
    o[1] = a[2] * b[0] - a[0] * b[2];
    o[2] = a[0] * b[1] - a[1] * b[0];
    return o;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // Update the shadow camera for one accepted item and queue the world
  // position it produces, if any.
  task automatic predict_world(logic [2:0] cmd, logic [95:0] data, logic follow);
    vec3_t v, d, fwd, rgt, upv, fb_fwd, fb_rgt, fb_up;
    logic [95:0] res;
    longint acc;
    for (int i = 0; i < 3; i++) v[i] = longint'($signed(data[32*i +: 32]));
    fb_fwd = '{0, 0, -(64'sd1 <<< BASIS_FRAC)};
    fb_rgt = '{64'sd1 <<< BASIS_FRAC, 0, 0};
    fb_up  = '{0, 64'sd1 <<< BASIS_FRAC, 0};
    case (cmd)
      CMD_LOAD_EYE:    cam_eye = v;
      CMD_LOAD_TARGET: cam_target = v;
      CMD_LOAD_UP: begin
        cam_up = v;
        cam_known = 1'b1;
      end
      CMD_ABSENT:      cam_known = 1'b0;
      CMD_TRANSFORM: begin
        if (!follow || !cam_known) begin
          for (int i = 0; i < 3; i++) res[32*i +: 32] = clamp32(v[i]);
        end else begin
          for (int i = 0; i < 3; i++) d[i] = cam_target[i] - cam_eye[i];
          fwd = unit_or(d, FRAC_BITS - SMALL_EXP, fb_fwd);
          rgt = unit_or(cross_prod(fwd, cam_up), T_RIGHT, fb_rgt);
          upv = unit_or(cross_prod(rgt, fwd), T_UP, fb_up);
          for (int i = 0; i < 3; i++) begin
            acc = (cam_eye[i] <<< BASIS_FRAC) + rgt[i] * v[0] + upv[i] * v[1] - fwd[i] * v[2];
            acc += 64'sd1 <<< (BASIS_FRAC - 1);
            res[32*i +: 32] = clamp32(acc >>> BASIS_FRAC);
          end
        end
        world_pos_q.push_back(res);
      end
      default: ;
    endcase
  endtask

  // Offer one item and hold it until the block takes it. The valid is only
  // lowered during an idle gap, so back-to-back items keep it high.
  task automatic send_item(logic [2:0] cmd, int x, int y, int z, logic follow);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {z, y, x};
    s_tuser  <= {follow, cmd};
    do @(posedge clk); while (!s_tready);
    predict_world(cmd, {z, y, x}, follow);
  endtask

  // Coordinates: mostly moderate values so the camera math does not just
  // saturate, plus full-range words, zero and the extremes.
  function automatic int rand_coord();
    case ($urandom_range(9))
      0, 1:    return $urandom;
      2:       return 0;
      3:       return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      4, 5:    return $signed($urandom_range(32'h1ff)) - 256;
      default: return $signed($urandom_range(32'h3fffff)) - 32'sh200000;
    endcase
  endfunction

  task automatic send_camera(int ex, int ey, int ez, int tx, int ty, int tz,
                             int ux, int uy, int uz);
    send_item(CMD_LOAD_EYE, ex, ey, ez, 1'b0);
    send_item(CMD_LOAD_TARGET, tx, ty, tz, 1'b0);
    send_item(CMD_LOAD_UP, ux, uy, uz, 1'b0);
  endtask

  // Receiver: random stalls, or one long hold-off counted here on request.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req && hold_left == 0) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        if (hold_left == 0) hold_req = 1'b0;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Result checker: every transfer on the output must match the oldest
  // expected world position, field by field.
  always @(posedge clk) begin
    logic [95:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (world_pos_q.size() == 0) begin
        $error("unexpected result %h", m_tdata);
        errors++;
      end else begin
        want = world_pos_q.pop_front();
        if (want[31:0] !== m_tdata[31:0]) begin
          $error("world_x expected %0d actual %0d", $signed(want[31:0]),
                 $signed(m_tdata[31:0]));
          errors++;
        end
        if (want[63:32] !== m_tdata[63:32]) begin
          $error("world_y expected %0d actual %0d", $signed(want[63:32]),
                 $signed(m_tdata[63:32]));
          errors++;
        end
        if (want[95:64] !== m_tdata[95:64]) begin
          $error("world_z expected %0d actual %0d", $signed(want[95:64]),
                 $signed(m_tdata[95:64]));
          errors++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither side transfers anything.
  always @(posedge clk) begin
    int quiet;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  // Directed items: extremes, every command, the ignored codes, and the
  // degenerate cameras that force each fallback axis.
  task automatic test_directed();
    // No camera yet: pass-through, even with follow set.
    send_item(CMD_TRANSFORM, 32'h7fffffff, 32'h80000000, 0, 1'b1);
    send_item(CMD_TRANSFORM, 32'hffffffff, 1, 32'h7fffffff, 1'b0);
    // Target equals eye and up is zero: forward and right fall back.
    send_camera(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(CMD_TRANSFORM, 256, 512, 768, 1'b1);
    // Forward along x with zero up: right falls back to x and so does the
    // cross product for up, giving the fixed up axis too.
    send_item(CMD_LOAD_TARGET, 25600, 0, 0, 1'b0);
    send_item(CMD_TRANSFORM, 256, -256, 1024, 1'b1);
    // Up parallel to forward.
    send_item(CMD_LOAD_UP, 512, 0, 0, 1'b0);
    send_item(CMD_TRANSFORM, 1000, 2000, 3000, 1'b1);
    // A usual camera and saturating inputs.
    send_camera(256, 512, 1024, 0, 0, -2560, 0, 256, 0);
    send_item(CMD_TRANSFORM, 2560, -1280, 640, 1'b1);
    send_item(CMD_TRANSFORM, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 1'b1);
    send_item(CMD_TRANSFORM, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 1'b0);
    // Extreme eye and target.
    send_camera(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                32'h80000000, 32'h7fffffff, 32'h80000000,
                32'h80000000, 32'h80000000, 32'h7fffffff);
    send_item(CMD_TRANSFORM, 32'h80000000, 0, 32'h7fffffff, 1'b1);
    // Ignored codes change nothing; follow is ignored by loads.
    send_item(CMD_SPARE_LO, 1, 2, 3, 1'b1);
    send_item(CMD_SPARE_HI, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b1);
    send_item(CMD_TRANSFORM, 100, 200, 300, 1'b1);
    // Camera absent, then a follow transform passes through.
    send_item(CMD_ABSENT, 7, 8, 9, 1'b1);
    send_item(CMD_TRANSFORM, 100, 200, 300, 1'b1);
  endtask

  // Mostly complete cameras followed by a few transforms, with some noise.
  task automatic test_random(int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) < 8) begin
        send_camera(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord(), rand_coord(), rand_coord());
        sent += 3;
        repeat ($urandom_range(1, 4)) begin
          send_item(CMD_TRANSFORM, rand_coord(), rand_coord(), rand_coord(),
                    $urandom_range(9) != 0);
          sent++;
        end
      end else begin
        send_item(3'($urandom_range(CMD_SPARE_HI)), rand_coord(), rand_coord(),
                  rand_coord(), $urandom_range(1));
        sent++;
      end
    end
  endtask

  // Hold the receiver off for a long stretch while the sender keeps
  // offering camera transforms, so the block backs up into its input.
  task automatic test_backpressure();
    send_camera(256, 0, 0, 256, 2560, 0, 0, 0, 256);
    hold_req = 1'b1;
    repeat (12) send_item(CMD_TRANSFORM, rand_coord(), rand_coord(), rand_coord(), 1'b1);
  endtask

  initial begin
    errors = 0;
    hold_req = 1'b0;
    src_idle_pct = 12;
    snk_idle_pct = 54;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    cam_eye = '{0, 0, 0};
    cam_target = '{0, 0, 0};
    cam_up = '{0, 0, 0};
    cam_known = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(320);
    src_idle_pct = 54;
    snk_idle_pct = 12;
    test_random(300);
    test_backpressure();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random(300);

    s_tvalid <= 1'b0;
    while (world_pos_q.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (errors == 0 && world_pos_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
